>>> hdl/dctq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dctq_pkg
// Shared types, widths and helpers for the delta-clock timer queue.
// ----------------------------------------------------------------------------
package dctq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int DELAY_BITS  = 16;
  localparam int EVENT_BITS  = 8;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    FN_INSERT = 1'b0,
    FN_TICK   = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_FIRED    = 2'd2,
    ST_IDLE     = 2'd3
  } status_e;

  // one queue slot: delay relative to the slot before it, event number
  typedef struct packed {
    logic [DELAY_BITS-1:0] delta;
    logic [EVENT_BITS-1:0] ev;
  } entry_t;

  // request handed from the stream port to the engine
  typedef struct packed {
    func_e                 func;
    logic [DELAY_BITS-1:0] delay;
    logic [EVENT_BITS-1:0] ev;
  } req_t;

  // one result beat
  typedef struct packed {
    status_e               status;
    logic [EVENT_BITS-1:0] ev;
    logic                  last;
  } res_t;

  // map a list position onto the circular buffer
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                               input logic [IDX_W-1:0] pos);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, pos};
    if (sum >= (IDX_W + 1)'(QUEUE_DEPTH)) begin
      sum = sum - (IDX_W + 1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

>>> hdl/dctq_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dctq_engine
// Sequencer and slot memory of the timer queue. The list lives in a circular
// buffer; inserts walk it once and ripple the tail up by one slot, ticks
// decrement the head and pop every expired entry.
// ----------------------------------------------------------------------------
module dctq_engine import dctq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_vld_i,
  output logic req_rdy_o,
  input  req_t req_i,
  output logic res_vld_o,
  input  logic res_rdy_i,
  output res_t res_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_WALK = 6'b000010,
    S_TAIL = 6'b000100,
    S_TDEC = 6'b001000,
    S_CHK  = 6'b010000,
    S_EMIT = 6'b100000
  } state_e;

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [IDX_W-1:0]      hd_q, hd_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [DELAY_BITS-1:0] rem_q, rem_d;
  logic [EVENT_BITS-1:0] ev_q, ev_d;
  logic                  found_q, found_d;
  entry_t                carry_q, carry_d;
  logic [EVENT_BITS-1:0] pend_q, pend_d;
  status_e               emit_q, emit_d;

  entry_t                mem [QUEUE_DEPTH];
  entry_t                rdata_q;
  logic                  we, re;
  logic [IDX_W-1:0]      wa, ra;
  entry_t                wd;
  logic [DELAY_BITS-1:0] dec;
  logic [IDX_W-1:0]      hd_nxt;

  assign dec    = rdata_q.delta - DELAY_BITS'(1);
  assign hd_nxt = slot_of(hd_q, IDX_W'(1));

  // sequence inserts and ticks through the slot memory
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    hd_d      = hd_q;
    idx_d     = idx_q;
    rem_d     = rem_q;
    ev_d      = ev_q;
    found_d   = found_q;
    carry_d   = carry_q;
    pend_d    = pend_q;
    emit_d    = emit_q;
    we        = 1'b0;
    wa        = hd_q;
    wd        = carry_q;
    re        = 1'b0;
    ra        = hd_q;
    res_vld_o = 1'b0;
    res_o     = '{status: ST_ACCEPTED, ev: '0, last: 1'b1};
    req_rdy_o = (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (req_vld_i) begin
          if (req_i.func == FN_INSERT) begin
            if (cnt_q == CNT_W'(QUEUE_DEPTH)) begin
              emit_d  = ST_FULL;
              state_d = S_EMIT;
            end else begin
              rem_d   = (req_i.delay == '0) ? DELAY_BITS'(1) : req_i.delay;
              ev_d    = req_i.ev;
              found_d = 1'b0;
              idx_d   = '0;
              if (cnt_q == '0) begin
                state_d = S_TAIL;
              end else begin
                re      = 1'b1;
                state_d = S_WALK;
              end
            end
          end else begin
            if (cnt_q == '0) begin
              emit_d  = ST_IDLE;
              state_d = S_EMIT;
            end else begin
              re      = 1'b1;
              state_d = S_TDEC;
            end
          end
        end
      end

      // one slot per cycle: compare or shift, prefetch the next slot
      S_WALK: begin
        we = 1'b1;
        wa = slot_of(hd_q, idx_q);
        re = 1'b1;
        ra = slot_of(hd_q, idx_q + IDX_W'(1));
        if (found_q) begin
          wd      = carry_q;
          carry_d = rdata_q;
        end else if (rem_q < rdata_q.delta) begin
          wd      = '{delta: rem_q, ev: ev_q};
          carry_d = '{delta: rdata_q.delta - rem_q, ev: rdata_q.ev};
          found_d = 1'b1;
        end else begin
          we    = 1'b0;
          rem_d = rem_q - rdata_q.delta;
        end
        if (CNT_W'(idx_q) + CNT_W'(1) == cnt_q) begin
          state_d = S_TAIL;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end

      // append the displaced slot or the new entry at the end
      S_TAIL: begin
        we      = 1'b1;
        wa      = slot_of(hd_q, cnt_q[IDX_W-1:0]);
        wd      = found_q ? carry_q : '{delta: rem_q, ev: ev_q};
        cnt_d   = cnt_q + CNT_W'(1);
        emit_d  = ST_ACCEPTED;
        state_d = S_EMIT;
      end

      // decrement the head; pop it if it expired
      S_TDEC: begin
        if (dec != '0) begin
          we      = 1'b1;
          wa      = hd_q;
          wd      = '{delta: dec, ev: rdata_q.ev};
          emit_d  = ST_IDLE;
          state_d = S_EMIT;
        end else begin
          pend_d = rdata_q.ev;
          hd_d   = hd_nxt;
          cnt_d  = cnt_q - CNT_W'(1);
          emit_d = ST_FIRED;
          if (cnt_q == CNT_W'(1)) begin
            state_d = S_EMIT;
          end else begin
            re      = 1'b1;
            ra      = hd_nxt;
            state_d = S_CHK;
          end
        end
      end

      // new head known: send the pending event, pop again on zero delta
      S_CHK: begin
        if (res_rdy_i) begin
          res_vld_o = 1'b1;
          if (rdata_q.delta == '0) begin
            res_o  = '{status: ST_FIRED, ev: pend_q, last: 1'b0};
            pend_d = rdata_q.ev;
            hd_d   = hd_nxt;
            cnt_d  = cnt_q - CNT_W'(1);
            if (cnt_q == CNT_W'(1)) begin
              state_d = S_EMIT;
            end else begin
              re = 1'b1;
              ra = hd_nxt;
            end
          end else begin
            res_o   = '{status: ST_FIRED, ev: pend_q, last: 1'b1};
            state_d = S_IDLE;
          end
        end
      end

      // final beat of the item
      S_EMIT: begin
        if (res_rdy_i) begin
          res_vld_o    = 1'b1;
          res_o.status = emit_q;
          res_o.ev     = (emit_q == ST_FIRED) ? pend_q : '0;
          res_o.last   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata_q <= mem[ra];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      hd_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      hd_q    <= hd_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    rem_q   <= rem_d;
    ev_q    <= ev_d;
    found_q <= found_d;
    carry_q <= carry_d;
    pend_q  <= pend_d;
    emit_q  <= emit_d;
  end

endmodule

>>> hdl/delta_clock_timer_queue_core.sv
`timescale 1ns / 1ps
// Delta-clock timer queue. A beat with tuser 0 inserts an event (tdata[15:0]
// delay in ticks, zero taken as one; tdata[23:16] event number); a beat with
// tuser 1 is one clock tick. Every insert returns one beat (tuser 0 accepted,
// 1 table full); a tick returns one beat per expired event (tuser 2, event in
// tdata, tlast on the final one) or a single tuser 3 beat if nothing expired.
// An insert walks the queued entries in the slot memory at one slot per cycle;
// a full table or an empty queue skips the walk. One item is in work at a
// time; the output register lets the next item start while the last beat
// waits. No clearing pass after reset.
// ----------------------------------------------------------------------------
// delta_clock_timer_queue_core
// Stream wrapper: unpacks the request beat and holds the result beat.
// ----------------------------------------------------------------------------
module delta_clock_timer_queue_core import dctq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [15:0] delay_ticks, [23:16] event_num
  input  logic        s_axis_tuser_i,   // [0] func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] fired_event
  output logic [1:0]  m_axis_tuser_o,   // [1:0] status
  output logic        m_axis_tlast_o    // last
);

  req_t req;
  res_t res, res_q;
  logic res_vld, res_rdy;
  logic vld_q, vld_d;

  assign req.func  = func_e'(s_axis_tuser_i);
  assign req.delay = s_axis_tdata_i[DELAY_BITS-1:0];
  assign req.ev    = s_axis_tdata_i[DELAY_BITS +: EVENT_BITS];

  dctq_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_vld_i (s_axis_tvalid_i),
    .req_rdy_o (s_axis_tready_o),
    .req_i     (req),
    .res_vld_o (res_vld),
    .res_rdy_i (res_rdy),
    .res_o     (res)
  );

  // output register takes a new beat when empty or draining
  assign res_rdy = !vld_q || m_axis_tready_i;

  always_comb begin
    vld_d = vld_q;
    if (res_vld) begin
      vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o  = res_q.ev;
  assign m_axis_tuser_o  = res_q.status;
  assign m_axis_tlast_o  = res_q.last;

endmodule

>>> hdl/dctq_sva.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dctq_sva
// Port-level checks of the timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module dctq_sva import dctq_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("result beat changed while stalled");

  // one item at a time: ready drops after an accepted beat
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second item taken while one is in work");

  // only fired events continue a run of beats
  a_mid_fired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> m_axis_tuser_o == ST_FIRED)
    else $error("non-final beat that is not a fired event");

  // status beats carry no event number
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != ST_FIRED |->
      m_axis_tlast_o && m_axis_tdata_o == '0)
    else $error("status beat malformed");

  // idle with a pending beat: it must be the final one of the last item
  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o && m_axis_tvalid_o |-> m_axis_tlast_o)
    else $error("ready while an item is still producing beats");

endmodule

bind delta_clock_timer_queue_core dctq_sva u_dctq_sva (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
